// ----- hw/rtl/ght_pkg.sv -----
// Shared types and constants for the generational handle table.
// Used by ght_phase_div, ght_seq and generational_handle_table_core.
package ght_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = 4;
   localparam int GEN_W      = 16;
   localparam int LIVE_W     = 5;
   localparam int PERIOD_W   = 8;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int LIST_AW    = SLOT_W + 1;

   localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RESOLVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   localparam logic LIST_DENSE = 1'b0;
   localparam logic LIST_FREE  = 1'b1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_POP,
      ST_GEN,
      ST_COMMIT,
      ST_LAST,
      ST_MOVE,
      ST_RETIRE,
      ST_PHASE,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic              live;
      logic [SLOT_W-1:0] dense;
      logic [GEN_W-1:0]  gen;
   } slot_entry_type;

   typedef struct packed {
      logic [LIVE_W-1:0]   live_count;
      logic [SLOT_W-1:0]   moved_from;
      logic                moved;
      logic [PERIOD_W-1:0] phase;
      logic [SLOT_W-1:0]   dense_index;
      logic [GEN_W-1:0]    generation;
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// ----- hw/rtl/ght_phase_div.sv -----
// Serial remainder unit: slot modulo max(1, update period), one bit per cycle.
// Depends on ght_pkg.
module ght_phase_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ght_pkg::SLOT_W-1:0]   dividend,
   input  logic [ght_pkg::PERIOD_W-1:0] period,
   output logic                         done,
   output logic [ght_pkg::PERIOD_W-1:0] remainder
);
   import ght_pkg::*;

   localparam int CNT_W = $clog2(SLOT_W);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_W-1:0] div_ff, div_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      done    = 1'b0;
      trial   = {rem_ff, dvd_ff[SLOT_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = (period == '0) ? PERIOD_W'(1) : period;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         dvd_in = {dvd_ff[SLOT_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SLOT_W - 1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/ght_seq.sv -----
// Request sequencer with the slot memory and the dense/free list memory.
// Depends on ght_pkg and ght_phase_div.
module ght_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ght_pkg::REQ_W-1:0]    req_kind,
   input  logic [ght_pkg::SLOT_W-1:0]   req_slot,
   input  logic [ght_pkg::GEN_W-1:0]    req_gen,
   input  logic [ght_pkg::PERIOD_W-1:0] period,
   output logic                         res_valid,
   input  logic                         res_ack,
   output ght_pkg::result_type          res
);
   import ght_pkg::*;

   seq_state_type state_ff, state_in;

   slot_entry_type    slot_mem [SLOT_COUNT];
   logic [SLOT_W-1:0] list_mem [2*SLOT_COUNT];

   slot_entry_type     slot_rd_ff;
   logic               slot_rd_en, slot_wr_en;
   logic [SLOT_W-1:0]  slot_rd_addr, slot_wr_addr;
   slot_entry_type     slot_wr_data;

   logic [SLOT_W-1:0]  list_rd_ff;
   logic               list_rd_en, list_wr_en;
   logic [LIST_AW-1:0] list_rd_addr, list_wr_addr;
   logic [SLOT_W-1:0]  list_wr_data;

   logic [REQ_W-1:0]    kind_ff, kind_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic [SLOT_W-1:0]   dense_ff, dense_in;
   logic [SLOT_W-1:0]   ms_ff, ms_in;
   logic                moved_ff, moved_in;
   logic [SLOT_W-1:0]   from_ff, from_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LIVE_W-1:0]   live_ff, live_in;
   logic [LIVE_W-1:0]   fd_ff, fd_in;
   logic [LIVE_W-1:0]   mark_ff, mark_in;

   logic [LIVE_W-1:0]   live_dec, fd_dec;
   logic [GEN_W-1:0]    gen_bump;
   logic                phase_start, phase_done;
   logic [PERIOD_W-1:0] phase;
   logic                ok;

   ght_phase_div u_phase_div (
      .clock     (clock),
      .reset     (reset),
      .start     (phase_start),
      .dividend  (slot_ff),
      .period    (period),
      .done      (phase_done),
      .remainder (phase)
   );

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[slot_rd_addr];
      end
      if (list_wr_en) begin
         list_mem[list_wr_addr] <= list_wr_data;
      end
      if (list_rd_en) begin
         list_rd_ff <= list_mem[list_rd_addr];
      end
   end

   assign live_dec = live_ff - LIVE_W'(1);
   assign fd_dec   = fd_ff - LIVE_W'(1);
   assign gen_bump = (gen_ff == '1) ? GEN_W'(1) : gen_ff + GEN_W'(1);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      gen_in       = gen_ff;
      dense_in     = dense_ff;
      ms_in        = ms_ff;
      moved_in     = moved_ff;
      from_in      = from_ff;
      status_in    = status_ff;
      live_in      = live_ff;
      fd_in        = fd_ff;
      mark_in      = mark_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      phase_start  = 1'b0;
      slot_rd_en   = 1'b0;
      slot_rd_addr = slot_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = slot_ff;
      slot_wr_data = '0;
      list_rd_en   = 1'b0;
      list_rd_addr = {LIST_DENSE, live_dec[SLOT_W-1:0]};
      list_wr_en   = 1'b0;
      list_wr_addr = {LIST_DENSE, dense_ff};
      list_wr_data = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_kind;
               slot_in   = req_slot;
               gen_in    = req_gen;
               dense_in  = '0;
               moved_in  = 1'b0;
               from_in   = '0;
               status_in = STATUS_OK;
               if (req_kind == REQ_ADD) begin
                  if (live_ff == LIVE_W'(SLOT_COUNT)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else if (fd_ff != '0) begin
                     list_rd_en   = 1'b1;
                     list_rd_addr = {LIST_FREE, fd_dec[SLOT_W-1:0]};
                     fd_in        = fd_dec;
                     state_in     = ST_POP;
                  end else begin
                     slot_in  = mark_ff[SLOT_W-1:0];
                     gen_in   = GEN_W'(1);
                     mark_in  = mark_ff + LIVE_W'(1);
                     state_in = ST_COMMIT;
                  end
               end else if ((req_kind != REQ_REMOVE && req_kind != REQ_RESOLVE)
                            || req_gen == '0 || {1'b0, req_slot} >= mark_ff) begin
                  status_in = STATUS_BAD;
                  state_in  = ST_DONE;
               end else begin
                  slot_rd_en   = 1'b1;
                  slot_rd_addr = req_slot;
                  state_in     = ST_LOOKUP;
               end
            end
         end
         ST_POP: begin
            slot_in      = list_rd_ff;
            slot_rd_en   = 1'b1;
            slot_rd_addr = list_rd_ff;
            state_in     = ST_GEN;
         end
         ST_GEN: begin
            gen_in   = (slot_rd_ff.gen == '0) ? GEN_W'(1) : slot_rd_ff.gen;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            slot_wr_en   = 1'b1;
            slot_wr_data = '{live: 1'b1, dense: live_ff[SLOT_W-1:0], gen: gen_ff};
            list_wr_en   = 1'b1;
            list_wr_addr = {LIST_DENSE, live_ff[SLOT_W-1:0]};
            list_wr_data = slot_ff;
            dense_in     = live_ff[SLOT_W-1:0];
            live_in      = live_ff + LIVE_W'(1);
            phase_start  = 1'b1;
            state_in     = ST_PHASE;
         end
         ST_LOOKUP: begin
            if (!slot_rd_ff.live || slot_rd_ff.gen != gen_ff) begin
               status_in = STATUS_BAD;
               state_in  = ST_DONE;
            end else begin
               dense_in = slot_rd_ff.dense;
               if (kind_ff == REQ_RESOLVE) begin
                  phase_start = 1'b1;
                  state_in    = ST_PHASE;
               end else if (slot_rd_ff.dense != live_dec[SLOT_W-1:0]) begin
                  list_rd_en   = 1'b1;
                  list_rd_addr = {LIST_DENSE, live_dec[SLOT_W-1:0]};
                  state_in     = ST_LAST;
               end else begin
                  state_in = ST_RETIRE;
               end
            end
         end
         ST_LAST: begin
            list_wr_en   = 1'b1;
            list_wr_addr = {LIST_DENSE, dense_ff};
            list_wr_data = list_rd_ff;
            slot_rd_en   = 1'b1;
            slot_rd_addr = list_rd_ff;
            ms_in        = list_rd_ff;
            moved_in     = 1'b1;
            from_in      = live_dec[SLOT_W-1:0];
            state_in     = ST_MOVE;
         end
         ST_MOVE: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = ms_ff;
            slot_wr_data = '{live: 1'b1, dense: dense_ff, gen: slot_rd_ff.gen};
            state_in     = ST_RETIRE;
         end
         ST_RETIRE: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = slot_ff;
            slot_wr_data = '{live: 1'b0, dense: '0, gen: gen_bump};
            list_wr_en   = 1'b1;
            list_wr_addr = {LIST_FREE, fd_ff[SLOT_W-1:0]};
            list_wr_data = slot_ff;
            fd_in        = fd_ff + LIVE_W'(1);
            live_in      = live_dec;
            phase_start  = 1'b1;
            state_in     = ST_PHASE;
         end
         ST_PHASE: begin
            if (phase_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ok = (status_ff == STATUS_OK);

   always_comb begin
      res             = '0;
      res.status      = status_ff;
      res.live_count  = live_ff;
      if (ok) begin
         res.slot        = slot_ff;
         res.generation  = gen_ff;
         res.dense_index = dense_ff;
         res.phase       = phase;
         res.moved       = moved_ff;
         res.moved_from  = from_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         live_ff  <= '0;
         fd_ff    <= '0;
         mark_ff  <= '0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         fd_ff    <= fd_in;
         mark_ff  <= mark_in;
      end
      kind_ff   <= kind_in;
      slot_ff   <= slot_in;
      gen_ff    <= gen_in;
      dense_ff  <= dense_in;
      ms_ff     <= ms_in;
      moved_ff  <= moved_in;
      from_ff   <= from_in;
      status_ff <= status_in;
   end

endmodule

// ----- hw/rtl/generational_handle_table_core.sv -----
// Top level of the generational handle table: stream ports, the update period
// register and the result register. Depends on ght_pkg, ght_seq and ght_phase_div.
//
// One transaction at a time is processed. An add commits a free or new slot, a remove
// moves the last dense entry when needed and retires the slot, and a resolve looks up
// the handle; each then runs the remainder unit, while a request that is rejected (full
// table, stale handle or bad request) goes straight to the result. The next request is
// taken once the result has moved into the output register. The work is a serial
// read-modify-write through the slot and list memories followed by the four-step
// remainder unit that produces the phase. Slots never used read as unused through the
// high-water mark, so no clearing pass follows reset.
module generational_handle_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // handle_slot[3:0], handle_generation[19:4], zero fill
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // slot_out[3:0], generation_out[19:4],
                                    // dense_index[23:20], phase_out[31:24], moved[32],
                                    // moved_from[36:33], live_count[41:37], zero fill
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // update_period[7:0]
);
   import ght_pkg::*;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;
   logic                res_valid, res_ack;
   result_type          res;

   ght_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_slot  (req_tdata[SLOT_W-1:0]),
      .req_gen   (req_tdata[SLOT_W+GEN_W-1:SLOT_W]),
      .period    (period_ff),
      .res_valid (res_valid),
      .res_ack   (res_ack),
      .res       (res)
   );

   assign res_ack = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {6'd0,
                        rsp_data_ff.live_count,
                        rsp_data_ff.moved_from,
                        rsp_data_ff.moved,
                        rsp_data_ff.phase,
                        rsp_data_ff.dense_index,
                        rsp_data_ff.generation,
                        rsp_data_ff.slot};

endmodule
